### rtl/core/assert_macros.svh
// assertion macros shared by the pid derivative block
// expects a clock named clock and an active-high reset named reset in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked at every edge outside reset
`define PFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define PFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/pfd_pkg.sv
// types and constants of the pid filtered derivative block
// no dependencies
package pfd_pkg;

   localparam int DATA_W    = 32;
   localparam int MUL_W     = 33;
   localparam int PROD_W    = 66;
   localparam int FRAC_BITS = 16;
   localparam int CNT_W     = 6;
   localparam int ALPHA_W   = 17;
   localparam int CSR_IDX_W = 3;

   // 0.001 s in q16.16
   localparam logic signed [DATA_W-1:0] DT_FALLBACK = 32'sd66;
   localparam logic signed [DATA_W-1:0] S32_MAX     = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] S32_MIN     = 32'sh8000_0000;

   // quotient bits produced per division
   localparam logic [CNT_W-1:0] DIV_SLOPE_BITS = 6'd32;
   localparam logic [CNT_W-1:0] DIV_ALPHA_BITS = 6'd17;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_TC = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INT_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MIN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MAX = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMITS_EN = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_INT,
      ST_INTEG,
      ST_SLOPE,
      ST_ALPHA,
      ST_DERIV,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC_D,
      ST_DRIVE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] count;
   } div_req_type;

   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic acc_clr;
   } mac_ctl_type;

endpackage

### rtl/core/pfd_div.sv
// shared radix-2 restoring divider, one quotient bit per clock
// depends on pfd_pkg and assert_macros.svh
`include "assert_macros.svh"

module pfd_div (
   input  logic                                clock,
   input  logic                                reset,
   input  pfd_pkg::div_req_type                req,
   input  logic [pfd_pkg::DATA_W-1:0]          rem_init,
   input  logic [pfd_pkg::DATA_W-1:0]          num_bits,
   input  logic [pfd_pkg::DATA_W-1:0]          divisor,
   output logic                                busy,
   output logic [pfd_pkg::DATA_W-1:0]          quot
);

   logic [pfd_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [pfd_pkg::DATA_W-1:0] rem_ff, rem_in;
   logic [pfd_pkg::DATA_W-1:0] quot_ff, quot_in;
   logic [pfd_pkg::DATA_W-1:0] div_ff, div_in;
   logic [pfd_pkg::DATA_W:0]   partial;
   logic [pfd_pkg::DATA_W:0]   diff;
   logic                       ge;

   assign busy = (cnt_ff != '0);
   assign quot = quot_ff;

   always_comb begin
      partial = {rem_ff, quot_ff[pfd_pkg::DATA_W-1]};
      ge      = (partial >= {1'b0, div_ff});
      diff    = partial - {1'b0, div_ff};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      div_in  = div_ff;
      if (req.start) begin
         cnt_in  = req.count;
         rem_in  = rem_init;
         quot_in = num_bits;
         div_in  = divisor;
      end else if (busy) begin
         cnt_in  = cnt_ff - 1'b1;
         rem_in  = ge ? diff[pfd_pkg::DATA_W-1:0] : partial[pfd_pkg::DATA_W-1:0];
         // dividend bits shift out at the top, quotient bits in at the bottom
         quot_in = {quot_ff[pfd_pkg::DATA_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   `PFD_ASSERT(a_div_no_restart, !(req.start && busy), "divider restarted while busy")
   `PFD_ASSERT(a_div_cnt_range, cnt_ff <= pfd_pkg::DIV_SLOPE_BITS, "divider count out of range")

endmodule

### rtl/core/pfd_mac.sv
// shared registered multiplier with a 66-bit accumulator behind it
// depends on pfd_pkg
module pfd_mac (
   input  logic                               clock,
   input  pfd_pkg::mac_ctl_type               ctl,
   input  logic signed [pfd_pkg::MUL_W-1:0]   op_a,
   input  logic signed [pfd_pkg::MUL_W-1:0]   op_b,
   output logic signed [pfd_pkg::PROD_W-1:0]  prod,
   output logic signed [pfd_pkg::PROD_W-1:0]  acc
);

   logic signed [pfd_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [pfd_pkg::PROD_W-1:0] acc_ff, acc_in;

   assign prod = prod_ff;
   assign acc  = acc_ff;

   always_comb begin
      prod_in = op_a * op_b;
      acc_in  = (ctl.acc_clr ? '0 : acc_ff) + prod_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

endmodule

### rtl/core/pid_filtered_derivative.sv
// pid controller with low-pass filtered derivative and integral anti-windup
// req_stall is high outside idle: one beat is finished before the next req beat is taken
// the 32- and 17-step divisions share the one divider and run one after the other
// rsp is a register: a stalled result holds while the next beat runs and waits in the drive step
// reset (synchronous, active high) clears gains, limits, integral, last error and
// filtered slope to zero and returns the sequencer to idle
`include "assert_macros.svh"

module pid_filtered_derivative (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [pfd_pkg::DATA_W-1:0]     req_error_sample,
   input  logic signed [pfd_pkg::DATA_W-1:0]     req_sample_period,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [pfd_pkg::DATA_W-1:0]     rsp_drive,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pfd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pfd_pkg::DATA_W-1:0]            csr_data
);

   // configuration registers
   logic signed [31:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic        [30:0] ftc_ff, ilim_ff;
   logic signed [31:0] dmin_ff, dmax_ff;
   logic               len_ff;

   // controller state kept between beats
   logic signed [31:0] isum_ff, last_ff, fslope_ff;

   // per-beat working registers
   logic signed [31:0] e_ff, dt_ff;
   logic signed [31:0] integ_ff, raw_ff, deriv_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_drive_ff;

   pfd_pkg::state_type state_ff, state_in;

   logic req_take, csr_take;
   logic signed [31:0] dt_fix;

   // sequencer outputs
   pfd_pkg::mac_ctl_type          mac_ctl;
   logic signed [pfd_pkg::MUL_W-1:0] mac_a, mac_b;
   logic signed [pfd_pkg::PROD_W-1:0] mac_prod, mac_acc;
   pfd_pkg::div_req_type          div_req;
   logic [31:0]                   div_rem_init, div_num_bits, div_divisor, div_q;
   logic                          div_busy;
   logic                          ld_integ, ld_raw, ld_deriv, ld_drive;

   // datapath
   logic signed [49:0] ed_floor;
   logic signed [50:0] integ_wide, ilim_pos, ilim_neg;
   logic signed [31:0] integ_clamp;
   logic signed [32:0] slope_diff;
   logic               slope_neg;
   logic        [32:0] slope_mag;
   logic        [31:0] slope_hi;
   logic               slope_ovf;
   logic signed [31:0] raw_sat;
   logic        [31:0] alpha_div;
   logic        [pfd_pkg::ALPHA_W-1:0] alpha;
   logic signed [31:0] deriv_new;
   logic signed [49:0] drive_wide, dmin_wide, dmax_wide;
   logic               drive_fits;
   logic signed [31:0] drive_out;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != pfd_pkg::ST_IDLE);
   assign csr_take  = csr_valid && csr_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   // non-positive period falls back to 1 ms
   assign dt_fix = (req_sample_period[31] || (req_sample_period == '0)) ?
                   pfd_pkg::DT_FALLBACK : req_sample_period;

   // integral: isum + floor(e*dt / 2^16), clamped to +/- limit
   always_comb begin
      ed_floor   = mac_prod[65:16];
      integ_wide = {{19{isum_ff[31]}}, isum_ff} + {ed_floor[49], ed_floor};
      ilim_pos   = {20'b0, ilim_ff};
      ilim_neg   = -ilim_pos;
      if (integ_wide > ilim_pos) begin
         integ_clamp = ilim_pos[31:0];
      end else if (integ_wide < ilim_neg) begin
         integ_clamp = ilim_neg[31:0];
      end else begin
         integ_clamp = integ_wide[31:0];
      end
   end

   // raw slope: |e - last| * 2^16 / dt divided as magnitude, sign fixed after
   // quotient above 32 bits is caught up front so the divider runs 32 steps
   always_comb begin
      slope_diff = {e_ff[31], e_ff} - {last_ff[31], last_ff};
      slope_neg  = slope_diff[32];
      slope_mag  = slope_neg ? 33'(-slope_diff) : 33'(slope_diff);
      slope_hi   = {15'b0, slope_mag[32:16]};
      slope_ovf  = (slope_hi >= $unsigned(dt_ff));
      if (!slope_neg) begin
         raw_sat = (slope_ovf || div_q[31]) ? pfd_pkg::S32_MAX : $signed(div_q);
      end else begin
         raw_sat = (slope_ovf || (div_q[31] && (|div_q[30:0]))) ?
                   pfd_pkg::S32_MIN : -$signed(div_q);
      end
   end

   // alpha = dt * 2^16 / (dt + tf), at most 2^16, so 17 quotient bits
   assign alpha_div = {1'b0, dt_ff[30:0]} + {1'b0, ftc_ff};
   assign alpha     = div_q[pfd_pkg::ALPHA_W-1:0];

   // filtered slope: true value fits 32 bits, so wraparound add is exact
   assign deriv_new = fslope_ff + mac_prod[47:16];

   // drive = floor(sum of products / 2^16), then clamp or saturate
   always_comb begin
      drive_wide = mac_acc[65:16];
      dmin_wide  = {{18{dmin_ff[31]}}, dmin_ff};
      dmax_wide  = {{18{dmax_ff[31]}}, dmax_ff};
      drive_fits = (drive_wide[49:31] == '0) || (drive_wide[49:31] == '1);
      if (len_ff) begin
         if (drive_wide < dmin_wide) begin
            drive_out = dmin_ff;
         end else if (drive_wide > dmax_wide) begin
            drive_out = dmax_ff;
         end else begin
            drive_out = drive_wide[31:0];
         end
      end else if (drive_fits) begin
         drive_out = drive_wide[31:0];
      end else begin
         drive_out = drive_wide[49] ? pfd_pkg::S32_MIN : pfd_pkg::S32_MAX;
      end
   end

   // sequencer: next state and unit controls
   always_comb begin
      state_in      = state_ff;
      mac_ctl       = '0;
      mac_a         = '0;
      mac_b         = '0;
      div_req       = '0;
      div_rem_init  = slope_hi;
      div_num_bits  = {slope_mag[15:0], 16'b0};
      div_divisor   = $unsigned(dt_ff);
      ld_integ      = 1'b0;
      ld_raw        = 1'b0;
      ld_deriv      = 1'b0;
      ld_drive      = 1'b0;
      case (state_ff)
         pfd_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = pfd_pkg::ST_MUL_INT;
            end
         end
         pfd_pkg::ST_MUL_INT: begin
            // e * dt
            mac_ctl.mul_en = 1'b1;
            mac_a          = {e_ff[31], e_ff};
            mac_b          = {dt_ff[31], dt_ff};
            state_in       = pfd_pkg::ST_INTEG;
         end
         pfd_pkg::ST_INTEG: begin
            ld_integ      = 1'b1;
            div_req.start = 1'b1;
            div_req.count = pfd_pkg::DIV_SLOPE_BITS;
            state_in      = pfd_pkg::ST_SLOPE;
         end
         pfd_pkg::ST_SLOPE: begin
            // alpha operands ride on the same divider
            div_rem_init = {1'b0, dt_ff[31:1]};
            div_num_bits = {dt_ff[0], 31'b0};
            div_divisor  = alpha_div;
            if (!div_busy) begin
               ld_raw        = 1'b1;
               div_req.start = 1'b1;
               div_req.count = pfd_pkg::DIV_ALPHA_BITS;
               state_in      = pfd_pkg::ST_ALPHA;
            end
         end
         pfd_pkg::ST_ALPHA: begin
            if (!div_busy) begin
               // (raw - filtered) * alpha
               mac_ctl.mul_en = 1'b1;
               mac_a          = {raw_ff[31], raw_ff} - {fslope_ff[31], fslope_ff};
               mac_b          = {16'b0, alpha};
               state_in       = pfd_pkg::ST_DERIV;
            end
         end
         pfd_pkg::ST_DERIV: begin
            ld_deriv       = 1'b1;
            mac_ctl.mul_en = 1'b1;
            mac_a          = {gain_p_ff[31], gain_p_ff};
            mac_b          = {e_ff[31], e_ff};
            state_in       = pfd_pkg::ST_MUL_I;
         end
         pfd_pkg::ST_MUL_I: begin
            mac_ctl.acc_en  = 1'b1;
            mac_ctl.acc_clr = 1'b1;
            mac_ctl.mul_en  = 1'b1;
            mac_a           = {gain_i_ff[31], gain_i_ff};
            mac_b           = {integ_ff[31], integ_ff};
            state_in        = pfd_pkg::ST_MUL_D;
         end
         pfd_pkg::ST_MUL_D: begin
            mac_ctl.acc_en = 1'b1;
            mac_ctl.mul_en = 1'b1;
            mac_a          = {gain_d_ff[31], gain_d_ff};
            mac_b          = {deriv_ff[31], deriv_ff};
            state_in       = pfd_pkg::ST_ACC_D;
         end
         pfd_pkg::ST_ACC_D: begin
            mac_ctl.acc_en = 1'b1;
            state_in       = pfd_pkg::ST_DRIVE;
         end
         pfd_pkg::ST_DRIVE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               ld_drive = 1'b1;
               state_in = pfd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfd_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = ld_drive || (rsp_valid_ff && rsp_stall);

   pfd_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .prod  (mac_prod),
      .acc   (mac_acc)
   );

   pfd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .rem_init (div_rem_init),
      .num_bits (div_num_bits),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quot     (div_q)
   );

   // control, configuration and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         ftc_ff       <= '0;
         ilim_ff      <= '0;
         dmin_ff      <= '0;
         dmax_ff      <= '0;
         len_ff       <= 1'b0;
         isum_ff      <= '0;
         last_ff      <= '0;
         fslope_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_take) begin
            case (csr_index)
               pfd_pkg::CSR_GAIN_P:    gain_p_ff <= csr_data;
               pfd_pkg::CSR_GAIN_I:    gain_i_ff <= csr_data;
               pfd_pkg::CSR_GAIN_D:    gain_d_ff <= csr_data;
               pfd_pkg::CSR_FILTER_TC: ftc_ff    <= csr_data[30:0];
               pfd_pkg::CSR_INT_LIMIT: ilim_ff   <= csr_data[30:0];
               pfd_pkg::CSR_DRIVE_MIN: dmin_ff   <= csr_data;
               pfd_pkg::CSR_DRIVE_MAX: dmax_ff   <= csr_data;
               pfd_pkg::CSR_LIMITS_EN: len_ff    <= csr_data[0];
               default: begin
               end
            endcase
         end
         // commit the new state together with the result beat
         if (ld_drive) begin
            isum_ff   <= integ_ff;
            fslope_ff <= deriv_ff;
            last_ff   <= e_ff;
         end
      end
   end

   // per-beat payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         e_ff  <= req_error_sample;
         dt_ff <= dt_fix;
      end
      if (ld_integ) begin
         integ_ff <= integ_clamp;
      end
      if (ld_raw) begin
         raw_ff <= raw_sat;
      end
      if (ld_deriv) begin
         deriv_ff <= deriv_new;
      end
      if (ld_drive) begin
         rsp_drive_ff <= drive_out;
      end
   end

   // an accepted beat always starts with the integral product
   `PFD_ASSERT_NEXT(a_accept_starts, req_valid && !req_stall, state_ff == pfd_pkg::ST_MUL_INT, "accepted beat did not start the sequence")
   // a new result only ever comes out of the drive step
   `PFD_ASSERT(a_rsp_from_drive, $rose(rsp_valid_ff) |-> ($past(state_ff) == pfd_pkg::ST_DRIVE), "result appeared outside the drive step")
   // both divisions are finished before the derivative product is used
   `PFD_ASSERT(a_div_idle_late, (state_ff == pfd_pkg::ST_DERIV) |-> !div_busy, "divider still busy after alpha step")

endmodule
